// ----- rtl/rmfc_pkg.sv -----
// Shared types and constants for the RESP message framer counter.
package rmfc_pkg;

  localparam int MAX_NESTING_DEFAULT = 8;
  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int COUNT_W = 16;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LINE,
    PH_LINE_CR,
    PH_HEAD,
    PH_HEAD_CR,
    PH_SKIP,
    PH_ERR
  } phase_t;

  typedef struct packed {
    logic push;
    logic finish;
    logic clear;
  } stack_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic top_end;
  } stack_stat_t;

endpackage

// ----- rtl/rmfc_ifs.sv -----
// Byte and result channel interfaces of the RESP message framer counter.
interface rmfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rmfc_out_if;
  logic        valid;
  logic        ready;
  logic        element_end;
  logic        format_error;
  logic [15:0] element_count;
  logic        buffer_done;

  modport source (output valid, output element_end, output format_error,
                  output element_count, output buffer_done, input ready);
  modport sink (input valid, input element_end, input format_error,
                input element_count, input buffer_done, output ready);
endinterface

// ----- rtl/rmfc_stack.sv -----
// Nesting stack of remaining array counts; one finish command can pop several levels at once.
module rmfc_stack #(
  parameter int MAX_NESTING = rmfc_pkg::MAX_NESTING_DEFAULT,
  parameter int LENGTH_BITS = rmfc_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rmfc_pkg::stack_cmd_t     cmd,
  input  logic [LENGTH_BITS-1:0]   push_value,
  output rmfc_pkg::stack_stat_t    stat
);

  localparam int LVL_W = $clog2(MAX_NESTING + 1);
  localparam int IDX_W = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  logic [LENGTH_BITS-1:0] remaining [MAX_NESTING];
  logic [MAX_NESTING-1:0] last_one;
  logic [LVL_W-1:0]       level;
  logic [LVL_W-1:0]       level_next;
  logic                   found;
  logic [IDX_W-1:0]       found_idx;
  logic [IDX_W-1:0]       push_idx;

  // The deepest open level whose count is not about to run out absorbs the finish.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < MAX_NESTING; i++) begin
      if ((LVL_W'(i) < level) && !last_one[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  assign push_idx = level[IDX_W-1:0];

  always_comb begin
    level_next = level;
    if (cmd.clear) begin
      level_next = '0;
    end else if (cmd.push) begin
      level_next = level + LVL_W'(1);
    end else if (cmd.finish) begin
      level_next = found ? LVL_W'(found_idx) + LVL_W'(1) : '0;
    end
  end

  assign stat.empty   = (level == '0);
  assign stat.full    = (level == LVL_W'(MAX_NESTING));
  assign stat.top_end = cmd.finish && !found;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      remaining[push_idx] <= push_value;
      last_one[push_idx]  <= (push_value == LENGTH_BITS'(1));
    end else if (cmd.finish && found) begin
      remaining[found_idx] <= remaining[found_idx] - LENGTH_BITS'(1);
      last_one[found_idx]  <= (remaining[found_idx] == LENGTH_BITS'(2));
    end
  end

endmodule

// ----- rtl/resp_message_framer_counter.sv -----
// Top level of the RESP message framer counter.
// The result transaction of an accepted byte is registered and offered in the next cycle.
// One byte per cycle unless results stall; header, skip and stack update settle in one pass.
// A held result does not stall input as long as the result side takes it in the same cycle.
// Reset clears the parse state, the nesting level, the count and command mode.
// The byte marked last returns the parse state to its reset values after its result.
module resp_message_framer_counter #(
  parameter int MAX_NESTING = rmfc_pkg::MAX_NESTING_DEFAULT,
  parameter int LENGTH_BITS = rmfc_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  rmfc_in_if.sink           bytes,
  rmfc_out_if.source        results
);

  rmfc_pkg::phase_t               phase;
  rmfc_pkg::phase_t               phase_next;
  logic                           hdr_array;
  logic                           hdr_array_next;
  logic                           hdr_neg;
  logic                           hdr_neg_next;
  logic [LENGTH_BITS-1:0]         hdr_value;
  logic [LENGTH_BITS-1:0]         hdr_value_next;
  logic [LENGTH_BITS:0]           skip_rem;
  logic [LENGTH_BITS:0]           skip_rem_next;
  logic [LENGTH_BITS:0]           skip_dec;
  logic [LENGTH_BITS+3:0]         hdr_mac;
  logic [3:0]                     digit;
  logic [rmfc_pkg::COUNT_W-1:0]   count;
  logic [rmfc_pkg::COUNT_W-1:0]   count_next;
  logic                           command_mode;
  logic                           accept;
  logic [7:0]                     b;
  rmfc_pkg::stack_cmd_t           stk_cmd;
  rmfc_pkg::stack_stat_t          stk_stat;

  assign accept       = bytes.valid && bytes.ready;
  assign bytes.ready  = !results.valid || results.ready;
  assign b            = bytes.data_byte;
  assign digit        = 4'(b - rmfc_pkg::CH_ZERO);
  assign hdr_mac      = ({4'b0, hdr_value} << 3) + ({4'b0, hdr_value} << 1)
                        + (LENGTH_BITS + 4)'(digit);
  assign skip_dec     = (skip_rem == '0) ? skip_rem : skip_rem - (LENGTH_BITS + 1)'(1);

  always_comb begin
    phase_next     = phase;
    hdr_array_next = hdr_array;
    hdr_neg_next   = hdr_neg;
    hdr_value_next = hdr_value;
    skip_rem_next  = skip_rem;
    stk_cmd        = '0;
    unique case (phase)
      rmfc_pkg::PH_LINE: begin
        if (b == rmfc_pkg::CH_CR) begin
          phase_next = rmfc_pkg::PH_LINE_CR;
        end
      end
      rmfc_pkg::PH_LINE_CR: begin
        if (b == rmfc_pkg::CH_LF) begin
          stk_cmd.finish = 1'b1;
          phase_next     = rmfc_pkg::PH_TYPE;
        end else if (b != rmfc_pkg::CH_CR) begin
          phase_next = rmfc_pkg::PH_LINE;
        end
      end
      rmfc_pkg::PH_HEAD: begin
        if (b == rmfc_pkg::CH_CR) begin
          phase_next = rmfc_pkg::PH_HEAD_CR;
        end else if (b == rmfc_pkg::CH_MINUS) begin
          hdr_neg_next = 1'b1;
        end else if (b >= rmfc_pkg::CH_ZERO && b <= rmfc_pkg::CH_NINE) begin
          if (|hdr_mac[LENGTH_BITS+3:LENGTH_BITS]) begin
            phase_next = rmfc_pkg::PH_ERR;
          end else begin
            hdr_value_next = hdr_mac[LENGTH_BITS-1:0];
          end
        end else begin
          phase_next = rmfc_pkg::PH_ERR;
        end
      end
      rmfc_pkg::PH_HEAD_CR: begin
        if (b != rmfc_pkg::CH_LF) begin
          phase_next = rmfc_pkg::PH_ERR;
        end else if (hdr_neg) begin
          stk_cmd.finish = 1'b1;
          phase_next     = rmfc_pkg::PH_TYPE;
        end else if (!hdr_array) begin
          skip_rem_next = {1'b0, hdr_value} + (LENGTH_BITS + 1)'(2);
          phase_next    = rmfc_pkg::PH_SKIP;
        end else if (hdr_value == '0) begin
          stk_cmd.finish = 1'b1;
          phase_next     = rmfc_pkg::PH_TYPE;
        end else if (stk_stat.full) begin
          phase_next = rmfc_pkg::PH_ERR;
        end else begin
          stk_cmd.push = 1'b1;
          phase_next   = rmfc_pkg::PH_TYPE;
        end
      end
      rmfc_pkg::PH_SKIP: begin
        skip_rem_next = skip_dec;
        if (skip_dec == '0) begin
          stk_cmd.finish = 1'b1;
          phase_next     = rmfc_pkg::PH_TYPE;
        end
      end
      rmfc_pkg::PH_ERR: begin
        phase_next = rmfc_pkg::PH_ERR;
      end
      default: begin
        if ((command_mode && stk_stat.empty && b != rmfc_pkg::CH_STAR)
            || !(b == rmfc_pkg::CH_STAR || b == rmfc_pkg::CH_DOLLAR)) begin
          if (b == rmfc_pkg::CH_PLUS || b == rmfc_pkg::CH_MINUS
              || b == rmfc_pkg::CH_COLON || b != rmfc_pkg::CH_CR) begin
            phase_next = rmfc_pkg::PH_LINE;
          end else begin
            phase_next = rmfc_pkg::PH_LINE_CR;
          end
        end else begin
          hdr_array_next = (b == rmfc_pkg::CH_STAR);
          hdr_neg_next   = 1'b0;
          hdr_value_next = '0;
          phase_next     = rmfc_pkg::PH_HEAD;
        end
      end
    endcase
    stk_cmd.push   = stk_cmd.push && accept;
    stk_cmd.finish = stk_cmd.finish && accept;
    stk_cmd.clear  = accept && bytes.last_byte;
  end

  always_comb begin
    count_next = count;
    if (stk_stat.top_end && count != '1) begin
      count_next = count + rmfc_pkg::COUNT_W'(1);
    end
  end

  rmfc_stack #(
    .MAX_NESTING (MAX_NESTING),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .cmd        (stk_cmd),
    .push_value (hdr_value),
    .stat       (stk_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      command_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      command_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= rmfc_pkg::PH_TYPE;
      hdr_array <= 1'b0;
      hdr_neg   <= 1'b0;
      hdr_value <= '0;
      skip_rem  <= '0;
      count     <= '0;
    end else if (accept) begin
      if (bytes.last_byte) begin
        phase     <= rmfc_pkg::PH_TYPE;
        hdr_array <= 1'b0;
        hdr_neg   <= 1'b0;
        hdr_value <= '0;
        skip_rem  <= '0;
        count     <= '0;
      end else begin
        phase     <= phase_next;
        hdr_array <= hdr_array_next;
        hdr_neg   <= hdr_neg_next;
        hdr_value <= hdr_value_next;
        skip_rem  <= skip_rem_next;
        count     <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.element_end   <= stk_stat.top_end;
      results.format_error  <= (phase_next == rmfc_pkg::PH_ERR);
      results.element_count <= count_next;
      results.buffer_done   <= bytes.last_byte;
    end
  end

endmodule

// ----- rtl/rmfc_checker.sv -----
// Port-level checker for the RESP message framer counter, bound to the top level.
module rmfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_element_end,
  input logic        out_format_error,
  input logic [15:0] out_element_count
);

  // A held result transaction stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before it was taken");

  // Every accepted byte produces a result in the following cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte gave no result in the next cycle");

  // An element end is always reflected in a nonzero count.
  a_end_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_element_end |-> out_element_count != 16'd0)
    else $error("element end reported with a zero count");

  // Once in error, no element end is reported.
  a_err_no_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_format_error |-> !out_element_end)
    else $error("element end reported while in error");

endmodule

bind resp_message_framer_counter rmfc_checker u_rmfc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (bytes.valid),
  .in_ready          (bytes.ready),
  .out_valid         (results.valid),
  .out_ready         (results.ready),
  .out_element_end   (results.element_end),
  .out_format_error  (results.format_error),
  .out_element_count (results.element_count)
);
